### design/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the tilt switch step counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 32;
   localparam int CFG_W   = 16;

   // Bus widths; the data buses are padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_USER_W = 2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GAP  = 1'b1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [CFG_W-1:0] MIN_GAP_RESET  = 16'd250;

   typedef enum logic [1:0] {
      REQ_POLL  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_TAKE  = 2'd2,
      REQ_ARM   = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic [TIME_W-1:0]  now_ms;
      logic               switch_closed;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] step_count;
      logic               report_valid;
      logic               settled_level;
      logic               dirty_flag;
   } result_type;

endpackage

`default_nettype wire

### design/tilt_switch_step_counter.sv
// ----------------------------------------------------------------------------
// tilt_switch_step_counter
// Debounced tilt switch step counter with minimum step gap.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_tready is high and returns exactly one
// result per request, in order. A request goes into an input register; when the
// result register is free or draining, the held request updates the counter state
// and loads the result register, which raises rsp_tvalid. The sustained rate is
// one item per cycle while rsp_tready stays high. The rate is set by the state
// update, since each request depends on the state the previous one left. Write
// the debounce and step gap registers only while no request is in flight.
`default_nettype none

module tilt_switch_step_counter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tss_pkg::REQ_DATA_W-1:0]    req_tdata,  // now_ms, switch_closed
   input  wire logic [tss_pkg::REQ_USER_W-1:0]    req_tuser,  // req_type
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // step_count, report_valid, settled_level, dirty_flag
   output logic [tss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [tss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tss_pkg::CFG_W-1:0]         csr_wdata
);

   logic                          in_valid_ff;
   tss_pkg::item_type             in_item_ff, in_item_in;
   logic                          out_valid_ff;
   tss_pkg::result_type           out_result_ff;
   tss_pkg::result_type           core_result;
   logic [tss_pkg::CFG_W-1:0]     debounce_ff;
   logic [tss_pkg::CFG_W-1:0]     min_gap_ff;
   logic                          advance;
   logic                          req_xfer;

   // advance the held item whenever the result slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.req_type      = tss_pkg::req_kind_type'(req_tuser);
      in_item_in.now_ms        = req_tdata[tss_pkg::TIME_W-1:0];
      in_item_in.switch_closed = req_tdata[tss_pkg::TIME_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= tss_pkg::DEBOUNCE_RESET;
         min_gap_ff  <= tss_pkg::MIN_GAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tss_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            tss_pkg::CSR_MIN_GAP:  min_gap_ff  <= csr_wdata;
            default:               debounce_ff <= debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
   end

   tss_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .item            (in_item_ff),
      .debounce_ms     (debounce_ff),
      .min_step_gap_ms (min_gap_ff),
      .result          (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        out_result_ff.dirty_flag,
                        out_result_ff.settled_level,
                        out_result_ff.report_valid,
                        out_result_ff.step_count};

endmodule

`default_nettype wire

### design/tss_core.sv
// ----------------------------------------------------------------------------
// tss_core
// Debounce, step gap check and step count state; updates once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_en,
   input  wire tss_pkg::item_type         item,
   input  wire logic [tss_pkg::CFG_W-1:0] debounce_ms,
   input  wire logic [tss_pkg::CFG_W-1:0] min_step_gap_ms,
   output tss_pkg::result_type            result
);

   logic                          raw_ff, raw_in;
   logic                          stable_ff, stable_in;
   logic [tss_pkg::TIME_W-1:0]    edge_ff, edge_in;
   logic [tss_pkg::TIME_W-1:0]    last_ff, last_in;
   logic                          has_ff, has_in;
   logic [tss_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          dirty_ff, dirty_in;
   logic                          report;
   logic [tss_pkg::TIME_W-1:0]    hold_time;
   logic [tss_pkg::TIME_W-1:0]    gap_time;

   always_comb begin
      raw_in    = raw_ff;
      stable_in = stable_ff;
      edge_in   = edge_ff;
      last_in   = last_ff;
      has_in    = has_ff;
      count_in  = count_ff;
      dirty_in  = dirty_ff;
      report    = 1'b0;
      hold_time = '0;
      gap_time  = item.now_ms - last_ff;
      case (item.req_type)
         tss_pkg::REQ_POLL: begin
            // a level change restarts the settle timer
            if (item.switch_closed != raw_ff) begin
               raw_in  = item.switch_closed;
               edge_in = item.now_ms;
            end
            hold_time = item.now_ms - edge_in;
            if (hold_time >= {16'd0, debounce_ms} && item.switch_closed != stable_ff) begin
               stable_in = item.switch_closed;
               if (!has_ff || gap_time >= {16'd0, min_step_gap_ms}) begin
                  last_in  = item.now_ms;
                  has_in   = 1'b1;
                  count_in = count_ff + 1'b1;
                  dirty_in = 1'b1;
               end
            end
         end
         tss_pkg::REQ_CLEAR: begin
            count_in = '0;
            dirty_in = 1'b1;
         end
         tss_pkg::REQ_TAKE: begin
            report   = dirty_ff;
            dirty_in = 1'b0;
         end
         tss_pkg::REQ_ARM: begin
            raw_in    = item.switch_closed;
            stable_in = item.switch_closed;
            edge_in   = item.now_ms;
            last_in   = '0;
            has_in    = 1'b0;
            count_in  = '0;
            dirty_in  = 1'b0;
         end
         default: begin
            report = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.step_count    = count_in;
      result.report_valid  = report;
      result.settled_level = stable_in;
      result.dirty_flag    = dirty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= 1'b0;
         edge_ff   <= '0;
         last_ff   <= '0;
         has_ff    <= 1'b0;
         count_ff  <= '0;
         dirty_ff  <= 1'b0;
      end else if (step_en) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         edge_ff   <= edge_in;
         last_ff   <= last_in;
         has_ff    <= has_in;
         count_ff  <= count_in;
         dirty_ff  <= dirty_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && !dirty_ff && !has_ff))
      else $error("state not cleared by reset");

   a_arm_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.req_type == tss_pkg::REQ_ARM) |=>
         (count_ff == '0 && !dirty_ff && !has_ff && stable_ff == raw_ff))
      else $error("arm did not restart state");

   a_poll_counts_by_one: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.req_type == tss_pkg::REQ_POLL) |=>
         (count_ff == $past(count_ff) ||
          count_ff == tss_pkg::COUNT_W'($past(count_ff) + 1'b1)))
      else $error("poll moved count by more than one");

   a_step_marks: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.req_type == tss_pkg::REQ_POLL && count_in != count_ff) |=>
         (dirty_ff && has_ff && last_ff == $past(item.now_ms)))
      else $error("counted step did not update marks");

   a_take_clears_dirty: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.req_type == tss_pkg::REQ_TAKE) |=> (!dirty_ff && $stable(count_ff)))
      else $error("take did not clear dirty mark");

   a_level_held: assert property (@(posedge clock) disable iff (reset)
      (step_en && (item.req_type == tss_pkg::REQ_CLEAR ||
                   item.req_type == tss_pkg::REQ_TAKE)) |=> $stable(stable_ff))
      else $error("settled level moved outside poll or arm");

endmodule

`default_nettype wire
